FILE: hdl/min_gap_and_range_tracker_defines.svh
// ----------------------------------------------------------------------------
// min_gap_and_range_tracker_defines
// Assertion macros shared by the tracker RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MIN_GAP_AND_RANGE_TRACKER_DEFINES_SVH
`define MIN_GAP_AND_RANGE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// implication or plain property, checked on every rising edge out of reset
`define MGRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");
// condition that must never be true
`define MGRT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define MGRT_ASSERT(lbl, clk, rstn, prop)
`define MGRT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: hdl/mgrt_pkg.sv
// ----------------------------------------------------------------------------
// mgrt_pkg
// Shared constants and helpers of the minimum-gap and range tracker.
// ----------------------------------------------------------------------------
package mgrt_pkg;

  // data and configuration widths
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CAP_W           = 11;
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  localparam logic [CAP_W-1:0]  CAP_RESET = 11'd1024;
  localparam logic [DATA_W-1:0] GAP_RESET = '1;

  // result status codes
  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  // two's complement order
  function automatic logic signed_lt(input logic [DATA_W-1:0] a,
                                     input logic [DATA_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

FILE: hdl/min_gap_and_range_tracker.sv
// ----------------------------------------------------------------------------
// min_gap_and_range_tracker
// Stores signed values up to a set capacity and reports the smallest gap
// between any two held values and the span from least to greatest.
// ----------------------------------------------------------------------------
// Sequence: a rejected value goes from accept straight to result; a value
//   stored into an empty store passes write and result, one for a non-empty
//   store passes a scan of all held values through the single store read port
//   and the gap unit, drain, write and result. No new item is taken until idle.
// Reset: count, least, greatest cleared, gap all ones, capacity 1024;
//   store contents are not cleared, no sweep after reset.
module min_gap_and_range_tracker #(
  parameter int unsigned MAX_ENTRIES = mgrt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mgrt_pkg::CAP_W-1:0]        cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mgrt_pkg::DATA_W-1:0] value_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              status_o,
  output logic                              span_valid_o,
  output logic [mgrt_pkg::DATA_W-1:0]       shortest_span_o,
  output logic [mgrt_pkg::DATA_W-1:0]       longest_span_o
);
  import mgrt_pkg::*;

`include "min_gap_and_range_tracker_defines.svh"

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_WRITE  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              rd_vld_q;
  logic [DATA_W-1:0] value_q;
  logic              status_q;
  logic [DATA_W-1:0] least_q, least_d;
  logic [DATA_W-1:0] greatest_q, greatest_d;
  logic              out_valid_q;
  logic              out_status_q, out_span_valid_q;
  logic [DATA_W-1:0] out_short_q, out_long_q;

  logic              in_accept;
  logic              out_load;
  logic              full;
  logic              scan_last;
  logic              mem_we, mem_re;
  logic [DATA_W-1:0] mem_rdata;
  logic [DATA_W-1:0] gap;
  logic [CMP_W-1:0]  cap_ext, max_ext, limit;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // effective capacity saturates at the store depth
  assign cap_ext = CMP_W'(cap_q);
  assign max_ext = CMP_W'(MAX_ENTRIES);
  assign limit   = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign full    = (CMP_W'(held_q) >= limit);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);
  assign scan_last  = (idx_q == (held_q - CNT_W'(1)));

  assign mem_re = (state_q == ST_SCAN);
  assign mem_we = (state_q == ST_WRITE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    idx_d      = idx_q;
    least_d    = least_q;
    greatest_d = greatest_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_accept) begin
          if (full) begin
            state_d = ST_RESULT;
          end else if (held_q == '0) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + CNT_W'(1);
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        held_d = held_q + CNT_W'(1);
        if (held_q == '0) begin
          least_d    = value_q;
          greatest_d = value_q;
        end else begin
          if (signed_lt(value_q, least_q)) begin
            least_d = value_q;
          end
          if (signed_lt(greatest_q, value_q)) begin
            greatest_d = value_q;
          end
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and tracked state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      held_q     <= '0;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      least_q    <= '0;
      greatest_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      held_q     <= held_d;
      idx_q      <= idx_d;
      rd_vld_q   <= mem_re;
      least_q    <= least_d;
      greatest_q <= greatest_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      value_q  <= value_i;
      status_q <= full ? STATUS_FULL : STATUS_STORED;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q     <= status_q;
      out_span_valid_q <= (held_q >= CNT_W'(2));
      if (held_q >= CNT_W'(2)) begin
        out_short_q <= gap;
        out_long_q  <= greatest_q - least_q;
      end else begin
        out_short_q <= '0;
        out_long_q  <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign span_valid_o    = out_span_valid_q;
  assign shortest_span_o = out_short_q;
  assign longest_span_o  = out_long_q;

  // value store
  mgrt_store #(
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (held_q[AW-1:0]),
    .wdata_i (value_q),
    .re_i    (mem_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // shared gap unit, one held value per cycle
  mgrt_gap_unit u_gap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (rd_vld_q),
    .new_i  (value_q),
    .old_i  (mem_rdata),
    .gap_o  (gap)
  );

  // checks
  `MGRT_ASSERT_NEVER(a_held_bound, clk_i, rst_ni, CMP_W'(held_q) > max_ext)
  `MGRT_ASSERT(a_full_keeps_count, clk_i, rst_ni, (in_accept && full) |=> (held_q == $past(held_q)))
  `MGRT_ASSERT(a_gap_idle_when_empty, clk_i, rst_ni, (held_q == '0) |-> (gap == GAP_RESET))
  `MGRT_ASSERT(a_span_order, clk_i, rst_ni, (out_valid_o && span_valid_o) |-> (longest_span_o >= shortest_span_o))

endmodule

FILE: hdl/mgrt_store.sv
// ----------------------------------------------------------------------------
// mgrt_store
// Value store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mgrt_store #(
  parameter int unsigned DEPTH = mgrt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [mgrt_pkg::DATA_W-1:0]                 wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [mgrt_pkg::DATA_W-1:0]                 rdata_o
);
  import mgrt_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mgrt_gap_unit.sv
// ----------------------------------------------------------------------------
// mgrt_gap_unit
// Shared gap unit: absolute difference of two values, folded into the
// running smallest gap one pair per cycle while enabled.
// ----------------------------------------------------------------------------
module mgrt_gap_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [mgrt_pkg::DATA_W-1:0] new_i,
  input  logic [mgrt_pkg::DATA_W-1:0] old_i,
  output logic [mgrt_pkg::DATA_W-1:0] gap_o
);
  import mgrt_pkg::*;

  logic [DATA_W-1:0] gap_q, gap_d;
  logic [DATA_W-1:0] diff_fwd, diff_rev, diff;

  // both subtractions in parallel, sign order picks one
  assign diff_fwd = new_i - old_i;
  assign diff_rev = old_i - new_i;
  assign diff     = signed_lt(new_i, old_i) ? diff_rev : diff_fwd;

  always_comb begin
    gap_d = gap_q;
    if (en_i && (diff < gap_q)) begin
      gap_d = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GAP_RESET;
    end else begin
      gap_q <= gap_d;
    end
  end

  assign gap_o = gap_q;

endmodule
